/* design/rnd256_pkg.sv */
// shared types, constants and byte functions of the rijndael-256 cipher
package rnd256_pkg;

    localparam int ROUND_KEY_HALVES = 30;
    localparam int NUM_ROUNDS       = ROUND_KEY_HALVES / 2 - 1;
    localparam int KEY_WORDS        = ROUND_KEY_HALVES * 4;
    localparam int KEY_CNT_W        = $clog2(KEY_WORDS + 1);
    localparam int CFG_INDEX_W      = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    // op codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [31:0][7:0] state_t;

    typedef struct packed {
        logic        op;
        logic [63:0] block_word3;
        logic [63:0] block_word2;
        logic [63:0] block_word1;
        logic [63:0] block_word0;
        logic        last_block;
    } rnd_in_t;

    typedef struct packed {
        logic [63:0] result_word3;
        logic [63:0] result_word2;
        logic [63:0] result_word1;
        logic [63:0] result_word0;
        logic        result_last;
    } rnd_out_t;

    typedef struct packed {
        logic   op;
        logic   last;
        state_t st;
    } pipe_item_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    // table builder, evaluated at elaboration only
    function automatic logic [255:0][7:0] build_sbox(input logic inverse);
        logic [255:0][7:0] tab;
        logic [7:0]        inv;
        logic [7:0]        s;
        logic [7:0]        xb;
        tab = '0;
        for (int x = 0; x < 256; x++) begin
            xb  = 8'(x);
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gmul(xb, 8'(y)) == 8'h01) inv = 8'(y);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            if (inverse) tab[s] = xb;
            else tab[xb] = s;
        end
        return tab;
    endfunction

    localparam logic [255:0][7:0] SBOX     = build_sbox(1'b0);
    localparam logic [255:0][7:0] INV_SBOX = build_sbox(1'b1);

    localparam int ROW_SHIFT [4] = '{0, 1, 3, 4};

    function automatic state_t sub_bytes(input state_t st, input logic inverse);
        state_t o;
        for (int i = 0; i < 32; i++) o[i] = inverse ? INV_SBOX[st[i]] : SBOX[st[i]];
        return o;
    endfunction

    function automatic state_t shift_rows(input state_t st, input logic inverse);
        state_t o;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inverse) o[4 * ((c + ROW_SHIFT[r]) % 8) + r] = st[4 * c + r];
                else o[4 * c + r] = st[4 * ((c + ROW_SHIFT[r]) % 8) + r];
            end
        end
        return o;
    endfunction

    function automatic state_t mix_columns(input state_t st, input logic inverse);
        state_t     o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 8; c++) begin
            a0 = st[4 * c];
            a1 = st[4 * c + 1];
            a2 = st[4 * c + 2];
            a3 = st[4 * c + 3];
            if (inverse) begin
                o[4 * c]     = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
                o[4 * c + 1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
                o[4 * c + 2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
                o[4 * c + 3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
            end else begin
                o[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return o;
    endfunction

endpackage

/* design/rnd256_key_expander.sv */
// key registers and sequential round-key schedule, one key word per cycle
module rnd256_key_expander
    import rnd256_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output logic                   busy,
    output state_t                 round_keys [NUM_ROUNDS+1]
);

    logic [63:0]          key_low_reg, key_high_reg;
    logic [KEY_CNT_W-1:0] cnt_reg;
    logic [7:0]           rcon_reg;
    logic [3:0][31:0]     win_reg;
    logic [31:0]          kw_reg [KEY_WORDS];

    logic [127:0] key_all;
    logic [31:0]  t_word;
    logic [31:0]  word_next;
    logic         use_key, rot_step;

    assign busy     = (cnt_reg != KEY_CNT_W'(KEY_WORDS));
    assign key_all  = {key_high_reg, key_low_reg};
    assign use_key  = (cnt_reg < KEY_CNT_W'(4));
    assign rot_step = !use_key && (cnt_reg[1:0] == 2'b00);

    // rotword, subword and rcon on every fourth word
    always_comb begin
        t_word = win_reg[3];
        if (rot_step) begin
            t_word = {SBOX[win_reg[3][7:0]], SBOX[win_reg[3][31:24]],
                      SBOX[win_reg[3][23:16]], SBOX[win_reg[3][15:8]] ^ rcon_reg};
        end
        word_next = use_key ? key_all[32 * cnt_reg[1:0] +: 32] : (win_reg[0] ^ t_word);
    end

    // key registers and schedule counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            cnt_reg      <= '0;
            rcon_reg     <= 8'h01;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ;
            endcase
            cnt_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (busy) begin
            cnt_reg <= cnt_reg + KEY_CNT_W'(1);
            if (rot_step) rcon_reg <= xtime(rcon_reg);
        end
    end

    // key word store and sliding window of the last four words
    always_ff @(posedge aclk) begin
        if (busy && !cfg_we) begin
            kw_reg[cnt_reg[KEY_CNT_W-1:0]] <= word_next;
            win_reg <= {word_next, win_reg[3:1]};
        end
    end

    // round key r is key words 8r to 8r+7
    for (genvar r = 0; r <= NUM_ROUNDS; r++) begin : g_rk
        for (genvar j = 0; j < 8; j++) begin : g_w
            assign round_keys[r][4 * j +: 4] = kw_reg[8 * r + j];
        end
    end

endmodule

/* design/rnd256_round.sv */
// one registered cipher round, forward or inverse chosen by the word's op
module rnd256_round
    import rnd256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       final_round,
    input  state_t     enc_key,
    input  state_t     dec_key,
    input  logic       in_valid,
    input  pipe_item_t in_item,
    output logic       out_valid,
    output pipe_item_t out_item
);

    logic       valid_reg;
    pipe_item_t item_reg;
    pipe_item_t item_next;
    state_t     enc_st, dec_st;

    // forward: sub, shift, mix, key; inverse: shift, sub, key, mix; no mix in the final round
    always_comb begin
        enc_st = shift_rows(sub_bytes(in_item.st, 1'b0), 1'b0);
        if (!final_round) enc_st = mix_columns(enc_st, 1'b0);
        enc_st = enc_st ^ enc_key;
        dec_st = sub_bytes(shift_rows(in_item.st, 1'b1), 1'b1) ^ dec_key;
        if (!final_round) dec_st = mix_columns(dec_st, 1'b1);
        item_next    = in_item;
        item_next.st = (in_item.op == OP_DECRYPT) ? dec_st : enc_st;
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/rijndael256_block_cipher.sv */
// top level of the rijndael-256 ecb cipher pipeline
// Usage:
// - s_valid/s_ready carry one input word: a 256-bit block, op (0 encrypt,
//   1 decrypt) and a last-block flag; m_valid/m_ready carry the result word.
// - the key is written through cfg_we/cfg_index/cfg_data (index 0 key_low,
//   index 1 key_high) while no word is in flight.
// - after reset or any key write the schedule unit builds 120 key words at
//   one word per cycle; s_ready stays low until all 120 are built.
// - the datapath is 15 register stages: the initial key add, then one round
//   per stage.
// - while m_ready is high, one word per cycle is taken and delivered in steady
//   state; each stage holds one word, its round logic sets the clock period.
// - when the receiver stalls, the last stage holds its result and earlier
//   stages keep filling bubbles until the pipeline is full; then s_ready
//   drops until m_ready returns.
// - reset clears the key to zero, empties the pipeline and restarts the
//   schedule.
module rijndael256_block_cipher
    import rnd256_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rnd_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rnd_out_t               m_data
);

    logic       busy;
    state_t     round_keys [NUM_ROUNDS+1];
    logic       adv   [NUM_ROUNDS+1];
    logic       vld   [NUM_ROUNDS+1];
    pipe_item_t items [NUM_ROUNDS+1];

    logic       v0_reg;
    pipe_item_t item0_reg;
    pipe_item_t item0_next;
    logic       take;

    rnd256_key_expander u_keys (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (busy),
        .round_keys (round_keys)
    );

    // a stage moves when it is empty or its successor moves
    assign adv[NUM_ROUNDS] = !vld[NUM_ROUNDS] || m_ready;
    for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_adv
        assign adv[k] = !vld[k] || adv[k + 1];
    end

    assign s_ready = adv[0] && !busy;
    assign take    = s_valid && s_ready;

    // initial key add
    always_comb begin
        item0_next.op   = s_data.op;
        item0_next.last = s_data.last_block;
        item0_next.st   = {s_data.block_word3, s_data.block_word2,
                           s_data.block_word1, s_data.block_word0}
                          ^ ((s_data.op == OP_DECRYPT) ? round_keys[NUM_ROUNDS]
                                                       : round_keys[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv[0]) begin
            v0_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) item0_reg <= item0_next;
    end

    assign vld[0]   = v0_reg;
    assign items[0] = item0_reg;

    // round stages
    for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
        rnd256_round u_round (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (adv[k]),
            .final_round (1'(k == NUM_ROUNDS)),
            .enc_key     (round_keys[k]),
            .dec_key     (round_keys[NUM_ROUNDS - k]),
            .in_valid    (vld[k - 1]),
            .in_item     (items[k - 1]),
            .out_valid   (vld[k]),
            .out_item    (items[k])
        );
    end

    // result word
    assign m_valid             = vld[NUM_ROUNDS];
    assign m_data.result_word0 = items[NUM_ROUNDS].st[7:0];
    assign m_data.result_word1 = items[NUM_ROUNDS].st[15:8];
    assign m_data.result_word2 = items[NUM_ROUNDS].st[23:16];
    assign m_data.result_word3 = items[NUM_ROUNDS].st[31:24];
    assign m_data.result_last  = items[NUM_ROUNDS].last;

    // key write restarts the schedule, so no word is taken next cycle
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("word accepted during key schedule");

    // an accepted word lands in the first stage
    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> v0_reg)
        else $error("accepted word lost at pipeline entry");

    // a stalled result is neither dropped nor altered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // while the schedule runs the pipeline takes nothing
    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !take)
        else $error("word taken while schedule busy");

endmodule

/* tb/tb_rijndael256_block_cipher.sv */
// testbench of the rijndael-256 cipher: random and directed words checked against a local model
module tb_rijndael256_block_cipher;
    import rnd256_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [31:0][7:0] blk_t;

    // directed word table
    typedef struct packed {
        logic        op;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic        last;
    } vec_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 200;

    logic           aclk;
    logic           aresetn;
    logic           cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]    cfg_data;
    logic           s_valid;
    logic           s_ready;
    rnd_in_t        s_data;
    logic           m_valid;
    logic           m_ready;
    rnd_out_t       m_data;

    rnd_out_t   expected_blocks[$];
    int         err_count;
    int         idle_cycles;
    logic       word_taken;
    logic       quiet;
    logic       hold_req;

    logic [7:0] fwd_sbox [256];
    logic [7:0] rev_sbox [256];
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [7:0] sched [480];

    rijndael256_block_cipher dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // field arithmetic
    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    task automatic make_boxes();
        logic [7:0] iv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            iv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (fmul(8'(x), 8'(y)) == 8'h01) iv = 8'(y);
            s = iv ^ rol8(iv, 1) ^ rol8(iv, 2) ^ rol8(iv, 3) ^ rol8(iv, 4) ^ 8'h63;
            fwd_sbox[x] = s;
            rev_sbox[s] = 8'(x);
        end
    endtask

    // key schedule for a 128-bit key, rcon running on
    task automatic expand_schedule();
        logic [7:0] t [4];
        logic [7:0] t0;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            sched[i]     = key_lo[8*i +: 8];
            sched[8 + i] = key_hi[8*i +: 8];
        end
        for (int w = 4; w < 120; w++) begin
            for (int b = 0; b < 4; b++) t[b] = sched[4*(w-1) + b];
            if ((w % 4) == 0) begin
                t0   = t[0];
                t[0] = fwd_sbox[t[1]] ^ rc;
                t[1] = fwd_sbox[t[2]];
                t[2] = fwd_sbox[t[3]];
                t[3] = fwd_sbox[t0];
                rc   = dbl(rc);
            end
            for (int b = 0; b < 4; b++) sched[4*w + b] = sched[4*(w-4) + b] ^ t[b];
        end
    endtask

    function automatic blk_t key_mix(input blk_t st, input int rnd);
        for (int i = 0; i < 32; i++) st[i] ^= sched[32*rnd + i];
        return st;
    endfunction

    function automatic blk_t row_rotate(input blk_t st, input logic inv);
        blk_t o;
        int   sh [4];
        int   src;
        sh = '{0, 1, 3, 4};
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + sh[r]) % 8) + r;
                if (inv) o[src] = st[4*c + r];
                else o[4*c + r] = st[src];
            end
        return o;
    endfunction

    function automatic blk_t column_mix(input blk_t st, input logic inv);
        blk_t       o;
        logic [7:0] m [4];
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 4; r++) begin
                o[4*c + r] = 8'h00;
                for (int k = 0; k < 4; k++) o[4*c + r] ^= fmul(st[4*c + k], m[(4 + k - r) % 4]);
            end
        return o;
    endfunction

    function automatic blk_t byte_sub(input blk_t st, input logic inv);
        for (int i = 0; i < 32; i++) st[i] = inv ? rev_sbox[st[i]] : fwd_sbox[st[i]];
        return st;
    endfunction

    // expected cipher output of one input word
    function automatic rnd_out_t cipher_block(input rnd_in_t w);
        blk_t     st;
        rnd_out_t o;
        st = {w.block_word3, w.block_word2, w.block_word1, w.block_word0};
        if (w.op == OP_ENCRYPT) begin
            st = key_mix(st, 0);
            for (int r = 1; r <= 14; r++) begin
                st = row_rotate(byte_sub(st, 1'b0), 1'b0);
                if (r != 14) st = column_mix(st, 1'b0);
                st = key_mix(st, r);
            end
        end else begin
            st = key_mix(st, 14);
            for (int r = 13; r >= 0; r--) begin
                st = key_mix(byte_sub(row_rotate(st, 1'b1), 1'b1), r);
                if (r != 0) st = column_mix(st, 1'b1);
            end
        end
        {o.result_word3, o.result_word2, o.result_word1, o.result_word0} = st;
        o.result_last = w.last_block;
        return o;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // handshake monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        rnd_out_t e;
        word_taken = s_valid && s_ready;
        if (word_taken) expected_blocks.push_back(cipher_block(s_data));
        if (m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                report("unexpected word", m_data.result_word0, 64'h0);
            end else begin
                e = expected_blocks.pop_front();
                if (m_data.result_word0 !== e.result_word0)
                    report("result_word0", m_data.result_word0, e.result_word0);
                if (m_data.result_word1 !== e.result_word1)
                    report("result_word1", m_data.result_word1, e.result_word1);
                if (m_data.result_word2 !== e.result_word2)
                    report("result_word2", m_data.result_word2, e.result_word2);
                if (m_data.result_word3 !== e.result_word3)
                    report("result_word3", m_data.result_word3, e.result_word3);
                if (m_data.result_last !== e.result_last)
                    report("result_last", 64'(m_data.result_last), 64'(e.result_last));
            end
        end
        if (word_taken || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic write_key(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_KEY_LOW) key_lo = val;
        else key_hi = val;
        expand_schedule();
    endtask

    // offer one word, hold it until taken; caller is at a falling edge
    task automatic send_word(input rnd_in_t w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(negedge aclk); while (!word_taken);
        s_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand_lane();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic rnd_in_t rand_word();
        rnd_in_t w;
        w.op          = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
        w.block_word0 = rand_lane();
        w.block_word1 = rand_lane();
        w.block_word2 = rand_lane();
        w.block_word3 = rand_lane();
        w.last_block  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic settle();
        @(negedge aclk);
        while (expected_blocks.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // main stimulus
    initial begin
        vec_t    vecs [$];
        rnd_in_t w;
        err_count = 0;
        idle_cycles = 0;
        word_taken = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_LOW;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        key_lo = '0;
        key_hi = '0;
        make_boxes();
        expand_schedule();
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        vecs = '{
            '{OP_ENCRYPT, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0},
            '{OP_DECRYPT, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1},
            '{OP_ENCRYPT, '1, '1, '1, '1, 1'b1},
            '{OP_DECRYPT, '1, '1, '1, '1, 1'b0},
            '{OP_ENCRYPT, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 1'b0},
            '{OP_DECRYPT, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 1'b1},
            '{OP_ENCRYPT, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555,
              64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0},
            '{OP_DECRYPT, 64'h1, 64'h0, 64'h0, 64'h8000000000000000, 1'b1},
            '{OP_ENCRYPT, 64'h8000000000000000, 64'h0, 64'h0, 64'h1, 1'b0},
            '{OP_DECRYPT, 64'h0, 64'h1, 64'h0, 64'h0, 1'b0},
            '{OP_ENCRYPT, 64'h0, 64'h0, 64'h1, 64'h0, 1'b1}
        };
        @(negedge aclk);
        foreach (vecs[i]) begin
            w = '{vecs[i].op, vecs[i].w3, vecs[i].w2, vecs[i].w1, vecs[i].w0, vecs[i].last};
            send_word(w);
        end
        settle();

        // phases over several keys, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_key(REG_KEY_LOW, '1);
                    write_key(REG_KEY_HIGH, '1);
                end
                1: begin
                    write_key(REG_KEY_LOW, 64'h0706050403020100);
                    write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
                end
                2: begin
                    write_key(REG_KEY_LOW, 64'h0);
                    write_key(REG_KEY_HIGH, '1);
                end
                default: begin
                    write_key(REG_KEY_LOW, {$urandom, $urandom});
                    write_key(REG_KEY_HIGH, {$urandom, $urandom});
                end
            endcase
            if (ph == 4) quiet = 1'b1;
            for (int n = 0; n < 200; n++) begin
                // long receiver hold-off while words keep coming
                if (ph == 1 && n == 20) hold_req = 1'b1;
                // sender waits for the pipeline to drain once
                if (ph == 2 && n == 100) while (expected_blocks.size() != 0) @(negedge aclk);
                send_word(rand_word());
            end
            settle();
        end

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
